// ===== rtl/core/ptq_pkg.sv =====
// ptq_pkg: shared types, codes and widths for the priority transmit queue
// used by ptq_regs, ptq_ctrl, ptq_dp and priority_tx_queue_flow_control
package ptq_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int NUM_CLASSES_DEF = 3;

	localparam int TAG_W     = 8;
	localparam int LEN_W     = 11;
	localparam int CMD_W     = 2;
	localparam int PRIO_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int OCLASS_W  = 2;
	localparam int CNT_W     = 8;
	localparam int THR_W     = 8;
	localparam int ENTRY_W   = TAG_W + LEN_W;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [THR_W-1:0] PAUSE_RESET  = 8'd100;
	localparam logic [THR_W-1:0] RESUME_RESET = 8'd20;
	localparam logic [CNT_W-1:0] PENDING_MAX  = 8'd255;

	// register index, taken from paddr[2]
	localparam logic REG_PAUSE  = 1'b0;
	localparam logic REG_RESUME = 1'b1;

	localparam int CLASS_NORMAL = 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_OPEN  = 2'd2,
		CMD_CLOSE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 3'd0,
		STS_BUSY   = 3'd1,
		STS_FULL   = 3'd2,
		STS_EMPTY  = 3'd3,
		STS_CLOSED = 3'd4
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_out;
	} ptq_cmd_t;

endpackage

// ===== rtl/core/ptq_regs.sv =====
// ptq_regs: apb configuration registers (pause and resume thresholds)
// depends on ptq_pkg
module ptq_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptq_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ptq_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ptq_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [ptq_pkg::THR_W-1:0]      pause_thr,
	output logic [ptq_pkg::THR_W-1:0]      resume_thr
);
	import ptq_pkg::*;

	logic [THR_W-1:0] pause_q;
	logic [THR_W-1:0] resume_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_q  <= PAUSE_RESET;
			resume_q <= RESUME_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_PAUSE:  pause_q  <= pwdata[THR_W-1:0];
				REG_RESUME: resume_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PAUSE:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, pause_q};
			REG_RESUME: prdata = {{(APB_DATA_W-THR_W){1'b0}}, resume_q};
			default:    prdata = '0;
		endcase
	end

	assign pause_thr  = pause_q;
	assign resume_thr = resume_q;

endmodule

// ===== rtl/core/ptq_ctrl.sv =====
// ptq_ctrl: sequencing state machine and output valid flag
// depends on ptq_pkg; drives ptq_dp through ptq_cmd_t
module ptq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ptq_pkg::ptq_cmd_t cmd
);
	import ptq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   in_fire;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_LOAD) && out_free);
	assign in_fire  = in_valid && in_ready;

	assign cmd.load_in  = in_fire;
	assign cmd.exec     = (state_q == ST_EXEC);
	assign cmd.load_out = (state_q == ST_LOAD) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_LOAD;
			ST_LOAD: begin
				// result goes out and the next transaction may start together
				if (out_free) state_d = in_fire ? ST_EXEC : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/ptq_dp.sv =====
// ptq_dp: class fifos (one shared entry memory), pointers, flow state, result regs
// depends on ptq_pkg; sequenced by ptq_ctrl
module ptq_dp #(
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_CLASSES = ptq_pkg::NUM_CLASSES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptq_pkg::ptq_cmd_t            cmd,
	input  logic [ptq_pkg::CMD_W-1:0]    command,
	input  logic [ptq_pkg::TAG_W-1:0]    buffer_tag,
	input  logic [ptq_pkg::LEN_W-1:0]    length,
	input  logic [ptq_pkg::PRIO_W-1:0]   priority_req,
	input  logic [ptq_pkg::THR_W-1:0]    pause_thr,
	input  logic [ptq_pkg::THR_W-1:0]    resume_thr,
	output logic [ptq_pkg::STATUS_W-1:0] status,
	output logic [ptq_pkg::TAG_W-1:0]    out_tag,
	output logic [ptq_pkg::LEN_W-1:0]    out_length,
	output logic [ptq_pkg::OCLASS_W-1:0] out_class,
	output logic                         paused,
	output logic [ptq_pkg::CNT_W-1:0]    pending
);
	import ptq_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int MEM_D  = NUM_CLASSES * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(MEM_D);
	localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0]  OCC_FULL = OCC_W'(QUEUE_DEPTH);
	localparam logic [CLS_W-1:0]  CLS_NORM = CLS_W'(CLASS_NORMAL);

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// captured transaction
	cmd_t              cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [LEN_W-1:0]  len_q;
	logic [PRIO_W-1:0] prio_q;

	// queue and flow state
	logic [PTR_W-1:0] rd_ptr_q [NUM_CLASSES];
	logic [PTR_W-1:0] wr_ptr_q [NUM_CLASSES];
	logic [OCC_W-1:0] occ_q    [NUM_CLASSES];
	logic [PTR_W-1:0] rd_ptr_d [NUM_CLASSES];
	logic [PTR_W-1:0] wr_ptr_d [NUM_CLASSES];
	logic [OCC_W-1:0] occ_d    [NUM_CLASSES];
	logic [CNT_W-1:0] pending_q, pending_d, pending_dec;
	logic             paused_q, paused_d;
	logic             open_q, open_d;

	// entry memory
	logic [ENTRY_W-1:0] mem_q [MEM_D];
	logic [ENTRY_W-1:0] mem_rdata_q;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;

	// pending result
	status_t          res_status_q, res_status_d;
	logic             res_deq_q, res_deq_d;
	logic [CLS_W-1:0] res_cls_q;

	// output register
	logic [STATUS_W-1:0] status_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [OCLASS_W-1:0] out_cls_q;
	logic                out_paused_q;
	logic [CNT_W-1:0]    out_pending_q;

	logic [CLS_W-1:0] enq_cls;
	logic [CLS_W-1:0] deq_cls;
	logic             deq_hit;

	always_comb begin
		enq_cls = (int'(prio_q) >= NUM_CLASSES) ? CLS_NORM : CLS_W'(prio_q);
	end

	// highest priority non-empty class
	always_comb begin
		deq_hit = 1'b0;
		deq_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (occ_q[c] != '0) begin
				deq_hit = 1'b1;
				deq_cls = CLS_W'(c);
			end
		end
	end

	assign mem_waddr   = ADDR_W'(enq_cls) * DEPTH_A + ADDR_W'(wr_ptr_q[enq_cls]);
	assign mem_raddr   = ADDR_W'(deq_cls) * DEPTH_A + ADDR_W'(rd_ptr_q[deq_cls]);
	assign pending_dec = (pending_q != '0) ? pending_q - CNT_W'(1) : pending_q;

	always_comb begin
		rd_ptr_d     = rd_ptr_q;
		wr_ptr_d     = wr_ptr_q;
		occ_d        = occ_q;
		pending_d    = pending_q;
		paused_d     = paused_q;
		open_d       = open_q;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		res_status_d = STS_OK;
		res_deq_d    = 1'b0;
		case (cmd_q)
			CMD_ENQ: begin
				if (!open_q) begin
					res_status_d = STS_CLOSED;
				end else if (enq_cls == CLS_NORM && pending_q >= pause_thr) begin
					// busy check wins over the full check
					paused_d     = 1'b1;
					res_status_d = STS_BUSY;
				end else if (occ_q[enq_cls] == OCC_FULL) begin
					res_status_d = STS_FULL;
				end else begin
					mem_we            = 1'b1;
					wr_ptr_d[enq_cls] = next_slot(wr_ptr_q[enq_cls]);
					occ_d[enq_cls]    = occ_q[enq_cls] + OCC_W'(1);
					if (enq_cls == CLS_NORM && pending_q != PENDING_MAX)
						pending_d = pending_q + CNT_W'(1);
				end
			end
			CMD_DEQ: begin
				if (!open_q) begin
					res_status_d = STS_CLOSED;
				end else if (!deq_hit) begin
					res_status_d = STS_EMPTY;
				end else begin
					mem_re            = 1'b1;
					res_deq_d         = 1'b1;
					rd_ptr_d[deq_cls] = next_slot(rd_ptr_q[deq_cls]);
					occ_d[deq_cls]    = occ_q[deq_cls] - OCC_W'(1);
					if (deq_cls == CLS_NORM) begin
						pending_d = pending_dec;
						if (paused_q && pending_dec < resume_thr) paused_d = 1'b0;
					end
				end
			end
			CMD_OPEN: begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					rd_ptr_d[c] = '0;
					wr_ptr_d[c] = '0;
					occ_d[c]    = '0;
				end
				pending_d = '0;
				paused_d  = 1'b0;
				open_d    = 1'b1;
			end
			CMD_CLOSE: open_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= cmd_t'(command);
			tag_q  <= buffer_tag;
			len_q  <= length;
			prio_q <= priority_req;
		end
		if (cmd.exec && mem_we) mem_q[mem_waddr] <= {len_q, tag_q};
		if (cmd.exec && mem_re) mem_rdata_q <= mem_q[mem_raddr];
		if (cmd.exec) begin
			res_status_q <= res_status_d;
			res_deq_q    <= res_deq_d;
			res_cls_q    <= deq_cls;
		end
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			out_tag_q     <= res_deq_q ? mem_rdata_q[TAG_W-1:0] : '0;
			out_len_q     <= res_deq_q ? mem_rdata_q[ENTRY_W-1:TAG_W] : '0;
			out_cls_q     <= res_deq_q ? OCLASS_W'(res_cls_q) : '0;
			out_paused_q  <= paused_q;
			out_pending_q <= pending_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				rd_ptr_q[c] <= '0;
				wr_ptr_q[c] <= '0;
				occ_q[c]    <= '0;
			end
			pending_q <= '0;
			paused_q  <= 1'b0;
			open_q    <= 1'b0;
		end else if (cmd.exec) begin
			rd_ptr_q  <= rd_ptr_d;
			wr_ptr_q  <= wr_ptr_d;
			occ_q     <= occ_d;
			pending_q <= pending_d;
			paused_q  <= paused_d;
			open_q    <= open_d;
		end
	end

	assign status     = status_q;
	assign out_tag    = out_tag_q;
	assign out_length = out_len_q;
	assign out_class  = out_cls_q;
	assign paused     = out_paused_q;
	assign pending    = out_pending_q;

endmodule

// ===== rtl/core/priority_tx_queue_flow_control.sv =====
// priority_tx_queue_flow_control: top level, strict priority tx queues with flow control
// depends on ptq_pkg, ptq_regs, ptq_ctrl, ptq_dp
//
// channel  signals                                                  handshake
// input    command, buffer_tag, length, priority_req                in_valid / in_ready
// output   status, out_tag, out_length, out_class, paused, pending  out_valid / out_ready
// config   psel, penable, pwrite, paddr, pwdata, prdata             pready (always high)
//
// each transaction passes through an execute state that updates the queue state and
// reads the entry memory, then a load state that fills the output register
// the next transaction is accepted in the load state while the output register is free;
// a stalled output register holds the load state until it drains
// reset clears pointers, counts and flags at once; the entry memory is not cleared
module priority_tx_queue_flow_control #(
	parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_CLASSES = ptq_pkg::NUM_CLASSES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ptq_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ptq_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ptq_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ptq_pkg::CMD_W-1:0]      command,
	input  logic [ptq_pkg::TAG_W-1:0]      buffer_tag,
	input  logic [ptq_pkg::LEN_W-1:0]      length,
	input  logic [ptq_pkg::PRIO_W-1:0]     priority_req,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ptq_pkg::STATUS_W-1:0]   status,
	output logic [ptq_pkg::TAG_W-1:0]      out_tag,
	output logic [ptq_pkg::LEN_W-1:0]      out_length,
	output logic [ptq_pkg::OCLASS_W-1:0]   out_class,
	output logic                           paused,
	output logic [ptq_pkg::CNT_W-1:0]      pending
);
	import ptq_pkg::*;

	logic [THR_W-1:0] pause_thr;
	logic [THR_W-1:0] resume_thr;
	ptq_cmd_t         cmd;

	ptq_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pause_thr  (pause_thr),
		.resume_thr (resume_thr)
	);

	ptq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ptq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_CLASSES (NUM_CLASSES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.command      (command),
		.buffer_tag   (buffer_tag),
		.length       (length),
		.priority_req (priority_req),
		.pause_thr    (pause_thr),
		.resume_thr   (resume_thr),
		.status       (status),
		.out_tag      (out_tag),
		.out_length   (out_length),
		.out_class    (out_class),
		.paused       (paused),
		.pending      (pending)
	);

`ifndef SYNTHESIS
	// one transaction in flight: the cycle after an accept never accepts
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is executing");

	// status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= STS_CLOSED))
		else $error("undefined status code");

	// entry fields are zero on every result whose status is not ok
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STS_OK) |->
			(out_tag == '0 && out_length == '0 && out_class == '0))
		else $error("entry fields set on a failed transaction");
`endif

endmodule

// ===== tb/sv/tb_priority_tx_queue_flow_control.sv =====
// tb_priority_tx_queue_flow_control: self-checking bench for the strict priority tx queue
// with pause/resume flow control; depends on ptq_pkg and priority_tx_queue_flow_control
// directed tests first, then random command streams under several threshold settings
`timescale 1ns / 1ps

module tb_priority_tx_queue_flow_control;
	import ptq_pkg::*;

	localparam int DEPTH          = QUEUE_DEPTH_DEF;
	localparam int NCLS           = NUM_CLASSES_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;

	localparam logic [PRIO_W-1:0] PRIO_HIGH   = 2'd0;
	localparam logic [PRIO_W-1:0] PRIO_NORMAL = 2'd1;
	localparam logic [PRIO_W-1:0] PRIO_LOW    = 2'd2;
	localparam logic [PRIO_W-1:0] PRIO_ALIAS  = 2'd3;

	typedef struct {
		status_t             status;
		logic [TAG_W-1:0]    tag;
		logic [LEN_W-1:0]    len;
		logic [OCLASS_W-1:0] cls;
		logic                paused;
		logic [CNT_W-1:0]    pending;
	} reply_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic [CMD_W-1:0]      command      = '0;
	logic [TAG_W-1:0]      buffer_tag   = '0;
	logic [LEN_W-1:0]      length       = '0;
	logic [PRIO_W-1:0]     priority_req = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b1;
	logic [STATUS_W-1:0]   status;
	logic [TAG_W-1:0]      out_tag;
	logic [LEN_W-1:0]      out_length;
	logic [OCLASS_W-1:0]   out_class;
	logic                  paused;
	logic [CNT_W-1:0]      pending;

	priority_tx_queue_flow_control uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .buffer_tag(buffer_tag), .length(length),
		.priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_tag(out_tag), .out_length(out_length),
		.out_class(out_class), .paused(paused), .pending(pending)
	);

	// scheduler shadow state
	logic [TAG_W-1:0] slot_tag [NCLS][DEPTH];
	logic [LEN_W-1:0] slot_len [NCLS][DEPTH];
	int               rd_ptr [NCLS];
	int               wr_ptr [NCLS];
	int               fill [NCLS];
	logic [CNT_W-1:0] pend_cnt;
	logic             pause_flag;
	logic             path_open;
	logic [THR_W-1:0] pause_thr;
	logic [THR_W-1:0] resume_thr;

	reply_t replies_due [$];
	int     errors       = 0;
	int     items_sent   = 0;
	int     results_seen = 0;
	int     resumes      = 0;
	int     status_count [5];
	bit     gaps_on      = 1'b1;

	initial forever #2 clk = ~clk;

	function automatic void flush_shadow();
		for (int c = 0; c < NCLS; c++) begin
			rd_ptr[c] = 0;
			wr_ptr[c] = 0;
			fill[c] = 0;
		end
		pend_cnt = '0;
		pause_flag = 1'b0;
	endfunction

	// expected reply of the queue block to one transaction, updating the shadow state
	function automatic reply_t scheduler_reply(cmd_t op, logic [TAG_W-1:0] tag,
			logic [LEN_W-1:0] len, logic [PRIO_W-1:0] prio);
		reply_t r;
		int     c;
		r.status = STS_OK;
		r.tag = '0;
		r.len = '0;
		r.cls = '0;
		case (op)
			CMD_ENQ: begin
				c = (prio >= NCLS) ? CLASS_NORMAL : int'(prio);
				if (!path_open) begin
					r.status = STS_CLOSED;
				end else if (c == CLASS_NORMAL && pend_cnt >= pause_thr) begin
					pause_flag = 1'b1;
					r.status = STS_BUSY;
				end else if (fill[c] >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					slot_tag[c][wr_ptr[c]] = tag;
					slot_len[c][wr_ptr[c]] = len;
					wr_ptr[c] = (wr_ptr[c] + 1) % DEPTH;
					fill[c]++;
					if (c == CLASS_NORMAL && pend_cnt < PENDING_MAX)
						pend_cnt++;
				end
			end
			CMD_DEQ: begin
				if (!path_open) begin
					r.status = STS_CLOSED;
				end else begin
					r.status = STS_EMPTY;
					for (int k = 0; k < NCLS; k++) begin
						if (r.status == STS_EMPTY && fill[k] != 0) begin
							r.status = STS_OK;
							r.tag = slot_tag[k][rd_ptr[k]];
							r.len = slot_len[k][rd_ptr[k]];
							r.cls = k[OCLASS_W-1:0];
							rd_ptr[k] = (rd_ptr[k] + 1) % DEPTH;
							fill[k]--;
							if (k == CLASS_NORMAL) begin
								if (pend_cnt != 0)
									pend_cnt--;
								if (pause_flag && pend_cnt < resume_thr) begin
									pause_flag = 1'b0;
									resumes++;
								end
							end
						end
					end
				end
			end
			CMD_OPEN: begin
				flush_shadow();
				path_open = 1'b1;
			end
			CMD_CLOSE: path_open = 1'b0;
		endcase
		r.paused = pause_flag;
		r.pending = pend_cnt;
		status_count[int'(r.status)]++;
		return r;
	endfunction

	// valid stays high after acceptance unless a gap follows; every other timed task lowers it
	task automatic send_op(cmd_t op, logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len,
			logic [PRIO_W-1:0] prio);
		in_valid <= 1'b1;
		command <= op;
		buffer_tag <= tag;
		length <= len;
		priority_req <= prio;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		replies_due.push_back(scheduler_reply(op, tag, len, prio));
		items_sent++;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	// write one threshold, then read it back
	task automatic reg_write(logic idx, logic [THR_W-1:0] val);
		in_valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DATA_W-THR_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_PAUSE)
			pause_thr = val;
		else
			resume_thr = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(APB_DATA_W-THR_W){1'b0}}, val}) begin
			$display("%0t: register %0d readback expected %0d actual %0d",
				$time, idx, val, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void field_check(string fname, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0d",
					$time, status);
				errors++;
			end else begin
				want = replies_due.pop_front();
				field_check("status", 32'(want.status), 32'(status));
				field_check("out_tag", 32'(want.tag), 32'(out_tag));
				field_check("out_length", 32'(want.len), 32'(out_length));
				field_check("out_class", 32'(want.cls), 32'(out_class));
				field_check("paused", 32'(want.paused), 32'(paused));
				field_check("pending", 32'(want.pending), 32'(pending));
			end
		end
	end

	// receiver: random stall bursts mixed with longer ready stretches
	initial begin
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_priority_tx_queue_flow_control: errors");
		$finish;
	end

	task automatic test_closed_after_reset();
		send_op(CMD_ENQ, 8'hff, 11'h7ff, PRIO_HIGH);
		send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_LOW);
		send_op(CMD_CLOSE, 8'h00, 11'h000, PRIO_NORMAL);
	endtask

	task automatic test_priority_order();
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h00, 11'h000, PRIO_LOW);
		send_op(CMD_ENQ, 8'hff, 11'h7ff, PRIO_ALIAS);
		send_op(CMD_ENQ, 8'h5a, 11'h2a5, PRIO_NORMAL);
		send_op(CMD_ENQ, 8'ha5, 11'h55a, PRIO_HIGH);
		repeat (5) send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
	endtask

	task automatic test_flush_and_close();
		send_op(CMD_ENQ, 8'h11, 11'h111, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h22, 11'h222, PRIO_NORMAL);
		// open on an open path still flushes
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h33, 11'h333, PRIO_NORMAL);
		send_op(CMD_ENQ, 8'h44, 11'h444, PRIO_ALIAS);
		send_op(CMD_CLOSE, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h55, 11'h555, PRIO_LOW);
		send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
	endtask

	task automatic test_hysteresis();
		wait_drain();
		reg_write(REG_PAUSE, 8'd3);
		reg_write(REG_RESUME, 8'd2);
		repeat (4) send_op(CMD_ENQ, TAG_W'($urandom_range(0, 255)),
			LEN_W'($urandom_range(0, 2047)), PRIO_NORMAL);
		send_op(CMD_ENQ, 8'h77, 11'h077, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h88, 11'h088, PRIO_LOW);
		// high class first, then normal drains count down through the resume point
		repeat (3) send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h99, 11'h099, PRIO_ALIAS);
		repeat (4) send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
	endtask

	task automatic test_threshold_zero();
		wait_drain();
		reg_write(REG_PAUSE, 8'd0);
		reg_write(REG_RESUME, 8'd0);
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_ENQ, 8'h01, 11'h001, PRIO_NORMAL);
		send_op(CMD_ENQ, 8'h02, 11'h002, PRIO_ALIAS);
		send_op(CMD_ENQ, 8'h03, 11'h003, PRIO_HIGH);
		send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
		send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
	endtask

	task automatic test_queue_full();
		wait_drain();
		reg_write(REG_PAUSE, 8'd2);
		reg_write(REG_RESUME, 8'd1);
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
		for (int i = 0; i <= DEPTH; i++)
			send_op(CMD_ENQ, i[TAG_W-1:0], LEN_W'(i * 13), PRIO_HIGH);
		// normal class pauses while the high class sits full
		repeat (3) send_op(CMD_ENQ, 8'h66, 11'h066, PRIO_NORMAL);
		// full high class while paused leaves the flag alone
		send_op(CMD_ENQ, 8'hee, 11'h0ee, PRIO_HIGH);
		repeat (3) send_op(CMD_DEQ, 8'h00, 11'h000, PRIO_HIGH);
	endtask

	task automatic random_op(int enq_pct);
		int   roll;
		cmd_t op;
		roll = $urandom_range(0, 99);
		if (!path_open)
			op = (roll < 60) ? CMD_OPEN : cmd_t'($urandom_range(0, 3));
		else if (roll < enq_pct)
			op = CMD_ENQ;
		else if (roll < 96)
			op = CMD_DEQ;
		else if (roll < 98)
			op = CMD_CLOSE;
		else
			op = CMD_OPEN;
		send_op(op, TAG_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 2047)),
			PRIO_W'($urandom_range(0, 3)));
	endtask

	task automatic test_random_phase(logic [THR_W-1:0] pause_v, logic [THR_W-1:0] resume_v,
			int enq_pct, int count);
		wait_drain();
		reg_write(REG_PAUSE, pause_v);
		reg_write(REG_RESUME, resume_v);
		send_op(CMD_OPEN, 8'h00, 11'h000, PRIO_HIGH);
		repeat (count) random_op(enq_pct);
	endtask

	initial begin
		path_open = 1'b0;
		pause_thr = PAUSE_RESET;
		resume_thr = RESUME_RESET;
		flush_shadow();
		for (int s = 0; s < 5; s++)
			status_count[s] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_closed_after_reset();
		test_priority_order();
		test_flush_and_close();
		test_hysteresis();
		test_threshold_zero();
		test_queue_full();
		test_random_phase(8'd6, 8'd2, 60, 40);
		test_random_phase(8'd0, 8'd0, 50, 30);
		test_random_phase(8'd128, 8'd128, 65, 40);
		test_random_phase(8'd10, 8'd10, 55, 40);
		wait_drain();
		gaps_on = 1'b0;
		test_random_phase(PAUSE_RESET, RESUME_RESET, 55, 60);

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d transactions, %0d results: ok %0d busy %0d full %0d",
			items_sent, results_seen, status_count[STS_OK], status_count[STS_BUSY],
			status_count[STS_FULL]);
		$display("empty %0d closed %0d, %0d resumes from pause",
			status_count[STS_EMPTY], status_count[STS_CLOSED], resumes);
		if (errors == 0)
			$display("tb_priority_tx_queue_flow_control: clean");
		else
			$display("tb_priority_tx_queue_flow_control: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ptq_pkg.sv
rtl/core/ptq_regs.sv
rtl/core/ptq_ctrl.sv
rtl/core/ptq_dp.sv
rtl/core/priority_tx_queue_flow_control.sv
tb/sv/tb_priority_tx_queue_flow_control.sv
